@@ hdl/ephy_pkg.sv @@
// package for the ethernet phy management register model
// types, codes and constants shared by the core and the top level
package ephy_pkg;

  typedef enum logic [2:0] {
    OP_ADVANCE  = 3'd0,
    OP_SET_PEER = 3'd1,
    OP_READ     = 3'd2,
    OP_WRITE    = 3'd3,
    OP_PIN      = 3'd4
  } op_e;

  localparam logic [4:0]  PhyAddress   = 5'd1;
  localparam logic [5:0]  PreambleBits = 6'd32;
  localparam logic [15:0] CtrlReset    = 16'h3100;
  localparam logic [15:0] AdvReset     = 16'h01e1;
  localparam logic [15:0] AbilityMask  = 16'h0de1;
  localparam logic [15:0] StatusBase   = 16'h7849;
  localparam logic [15:0] PhyId1       = 16'h001c;
  localparam logic [15:0] PhyId2       = 16'hc816;
  localparam logic [15:0] CtrlWrMask   = 16'hbf00;
  localparam logic [15:0] MmdData      = 16'h4007;
  localparam logic [5:0]  EeeAddr      = 6'h3c;
  localparam logic [13:0] EeeCfgReset  = 14'h3300;
  localparam logic [1:0]  EeeAdvReset  = 2'd2;
  localparam logic [5:0]  LedCtrlReset = 6'h30;
  localparam logic [1:0]  CfgResetDelay = 2'd0;
  localparam logic [1:0]  CfgNegDelay   = 2'd1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] now;
    logic        peer_present;
    logic [15:0] peer_ability;
    logic [4:0]  reg_index;
    logic [15:0] write_value;
    logic [3:0]  pin_value;
  } in_word_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] read_data;
    logic        link_up;
    logic        led0_valid;
    logic        led0_high;
    logic [3:0]  pin_readback;
    logic        deadline_pending;
    logic [63:0] deadline_time;
  } out_word_t;

  typedef struct packed {
    logic [63:0] time_now;
    logic [63:0] deadline_at;
    logic        deadline_armed;
    logic [15:0] control_reg;
    logic [15:0] advert_reg;
    logic [15:0] partner_reg;
    logic [1:0]  expansion_reg;
    logic        link_state;
    logic        link_latched_low;
    logic        peer_here;
    logic [15:0] peer_ability_word;
    logic        reset_in_progress;
    logic [2:0]  page_select;
    logic [5:0]  led_mode;
    logic [5:0]  led_ctrl;
    logic [13:0] eee_cfg;
    logic [1:0]  eee_adv;
    logic [14:0] mmd_ctrl;
    logic [5:0]  mmd_addr;
    logic [2:0]  pin_latch;
    logic        mdio_out;
    logic        in_frame;
    logic        need_idle;
    logic        synced;
    logic [5:0]  preamble_count;
    logic [5:0]  bit_count;
    logic [13:0] frame_header;
    logic [15:0] frame_data;
  } phy_state_t;

  function automatic phy_state_t reset_state();
    phy_state_t s;
    s = '0;
    s.control_reg      = CtrlReset;
    s.advert_reg       = AdvReset;
    s.partner_reg      = 16'd1;
    s.link_latched_low = 1'b1;
    s.led_ctrl         = LedCtrlReset;
    s.eee_cfg          = EeeCfgReset;
    s.eee_adv          = EeeAdvReset;
    s.mdio_out         = 1'b1;
    return s;
  endfunction

endpackage

@@ hdl/ephy_core.sv @@
// next-state and result logic for one word of the phy register model
// depends on ephy_pkg
module ephy_core import ephy_pkg::*; (
  input  phy_state_t st_i,
  input  in_word_t   in_i,
  input  logic [31:0] reset_delay_i,
  input  logic [31:0] neg_delay_i,
  output phy_state_t st_o,
  output out_word_t  out_o
);

  function automatic void link_drop(inout phy_state_t p);
    p.link_state       = 1'b0;
    p.link_latched_low = 1'b1;
    p.partner_reg      = 16'd1;
    p.expansion_reg    = 2'd0;
  endfunction

  function automatic logic set_deadline(inout phy_state_t p, input logic [31:0] d);
    logic [64:0] sum;
    sum = {1'b0, p.time_now} + {33'd0, d};
    if (sum >= 65'h0_ffff_ffff_ffff_ffff) return 1'b0;
    p.deadline_at    = sum[63:0];
    p.deadline_armed = 1'b1;
    return 1'b1;
  endfunction

  function automatic logic start_aneg(inout phy_state_t p, input logic [31:0] nd);
    link_drop(p);
    p.deadline_armed = 1'b0;
    p.deadline_at    = '0;
    if (p.peer_here && (p.control_reg & 16'h0c00) == 16'd0) return set_deadline(p, nd);
    p.control_reg = p.control_reg & ~16'h0200;
    return 1'b1;
  endfunction

  function automatic logic time_step(inout phy_state_t p, input logic [63:0] t,
                                     input logic [31:0] nd);
    logic [15:0] shared;
    logic [15:0] top;
    if (t < p.time_now || t == '1) return 1'b0;
    if (p.deadline_armed && t >= p.deadline_at) begin
      p.time_now       = p.deadline_at;
      p.deadline_armed = 1'b0;
      p.deadline_at    = '0;
      if (p.reset_in_progress) begin
        p.reset_in_progress = 1'b0;
        p.control_reg = CtrlReset;
        p.advert_reg  = AdvReset;
        p.page_select = '0;
        p.led_mode    = '0;
        p.led_ctrl    = LedCtrlReset;
        p.eee_cfg     = EeeCfgReset;
        p.eee_adv     = EeeAdvReset;
        p.mmd_ctrl    = '0;
        p.mmd_addr    = '0;
        if (!start_aneg(p, nd)) return 1'b0;
        if (p.deadline_armed && t >= p.deadline_at) begin
          p.deadline_armed = 1'b0;
          p.deadline_at    = '0;
        end
      end
      if (!p.deadline_armed && p.peer_here && (p.control_reg & 16'h0c00) == 16'd0) begin
        shared = p.advert_reg & p.peer_ability_word & 16'h01e0;
        if (shared != 16'd0) begin
          if (shared[8])      top = 16'h100;
          else if (shared[7]) top = 16'h080;
          else if (shared[6]) top = 16'h040;
          else                top = 16'h020;
          p.link_state    = 1'b1;
          p.partner_reg   = p.peer_ability_word | 16'h4000;
          p.expansion_reg = 2'd3;
          p.control_reg   = p.control_reg & ~16'h2300;
          if ((top & 16'h180) != 16'd0) p.control_reg = p.control_reg | 16'h2000;
          if ((top & 16'h140) != 16'd0) p.control_reg = p.control_reg | 16'h0100;
        end
        p.control_reg = p.control_reg & ~16'h0200;
      end
    end
    p.time_now = t;
    return 1'b1;
  endfunction

  function automatic logic reg_read(inout phy_state_t p, input logic [4:0] r,
                                    output logic [15:0] res);
    res = '0;
    if (r == 5'd31) begin
      res = {13'd0, p.page_select};
      return 1'b1;
    end
    if (p.page_select == 3'd7) begin
      if (r == 5'd17) res = {10'd0, p.led_mode};
      else if (r == 5'd19) res = {10'd0, p.led_ctrl};
      else return 1'b0;
      return 1'b1;
    end
    if (p.page_select == 3'd4) begin
      if (r != 5'd16) return 1'b0;
      res = {2'd0, p.eee_cfg};
      return 1'b1;
    end
    case (r)
      5'd0: res = p.control_reg;
      5'd1: begin
        res = StatusBase | (p.link_state ? 16'h20 : 16'h0) |
              ((p.link_state && !p.link_latched_low) ? 16'h4 : 16'h0);
        p.link_latched_low = 1'b0;
      end
      5'd2: res = PhyId1;
      5'd3: res = PhyId2;
      5'd4: res = p.advert_reg;
      5'd5: res = p.partner_reg;
      5'd6: begin
        res = {14'd0, p.expansion_reg};
        p.expansion_reg = p.expansion_reg & 2'd1;
      end
      5'd13: res = '0;
      5'd14: begin
        if (!p.mmd_ctrl[14]) res = {10'd0, p.mmd_addr};
        else if ({1'b0, p.mmd_ctrl} == MmdData && p.mmd_addr == EeeAddr)
          res = {14'd0, p.eee_adv};
        else return 1'b0;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic logic reg_write(inout phy_state_t p, input logic [4:0] r,
                                     input logic [15:0] w, input logic [31:0] rd_dly,
                                     input logic [31:0] nd);
    logic [15:0] prior;
    if (r == 5'd31) begin
      if (w != 16'd0 && w != 16'd4 && w != 16'd7) return 1'b0;
      p.page_select = w[2:0];
      return 1'b1;
    end
    if (p.page_select == 3'd7) begin
      if (r == 5'd17 && (w & ~16'h0033) == 16'd0) p.led_mode = w[5:0];
      else if (r == 5'd19 && (w & ~16'h0038) == 16'd0) p.led_ctrl = w[5:0];
      else return 1'b0;
      return 1'b1;
    end
    if (p.page_select == 3'd4) begin
      if (r != 5'd16 || (w & ~16'h3300) != 16'd0) return 1'b0;
      p.eee_cfg = w[13:0];
      return 1'b1;
    end
    if (r == 5'd13) begin
      if (w != 16'd7 && w != MmdData) return 1'b0;
      p.mmd_ctrl = w[14:0];
    end else if (r == 5'd14) begin
      if (p.mmd_ctrl == 15'd7 && w == 16'h3c) p.mmd_addr = w[5:0];
      else if ({1'b0, p.mmd_ctrl} == MmdData && p.mmd_addr == EeeAddr &&
               (w & ~16'd2) == 16'd0) p.eee_adv = w[1:0];
      else return 1'b0;
    end else if (r == 5'd4) begin
      if ((w & ~AbilityMask) != 16'd0 || w[4:0] != 5'd1 || p.reset_in_progress)
        return 1'b0;
      p.advert_reg = w;
    end else if (r == 5'd0) begin
      if ((w & ~CtrlWrMask) != 16'd0 || w[14]) return 1'b0;
      if (w[15]) begin
        link_drop(p);
        p.control_reg       = 16'hb100;
        p.reset_in_progress = 1'b1;
        p.synced            = 1'b0;
        p.preamble_count    = '0;
        if (!set_deadline(p, rd_dly)) return 1'b0;
      end else begin
        prior = p.control_reg;
        if (!w[12] || p.reset_in_progress) return 1'b0;
        p.control_reg = w;
        if (w[9] || ((prior ^ w) & 16'h0c00) != 16'd0) begin
          if (!start_aneg(p, nd)) return 1'b0;
        end
      end
    end else return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic mdc_rise(inout phy_state_t p, input logic host,
                                    input logic lvl, input logic [31:0] rd_dly,
                                    input logic [31:0] nd);
    logic [1:0] opc;
    logic [4:0] dev;
    if (!p.in_frame) begin
      if (p.need_idle) begin
        if (!lvl) return 1'b0;
        p.need_idle = 1'b0;
      end
      if (lvl) begin
        if (p.preamble_count < PreambleBits) p.preamble_count = p.preamble_count + 6'd1;
        return 1'b1;
      end
      if (!host || (!p.synced && p.preamble_count < PreambleBits)) return 1'b0;
      p.synced = 1'b1;
      p.in_frame = 1'b1;
      p.bit_count = 6'd1;
      p.frame_header = '0;
      p.preamble_count = '0;
      return 1'b1;
    end
    if (p.bit_count < 6'd14) begin
      if (!host) return 1'b0;
      p.frame_header = {p.frame_header[12:0], lvl};
      p.bit_count = p.bit_count + 6'd1;
      if (p.bit_count == 6'd2 && p.frame_header != 14'd1) return 1'b0;
      if (p.bit_count == 6'd4 && p.frame_header[1:0] != 2'd1 &&
          p.frame_header[1:0] != 2'd2) return 1'b0;
      return 1'b1;
    end
    opc = p.frame_header[11:10];
    dev = p.frame_header[9:5];
    if (opc == 2'd2) begin
      if (host) return 1'b0;
    end else begin
      if (!host) return 1'b0;
      if (p.bit_count == 6'd14 && lvl != 1'b1) return 1'b0;
      if (p.bit_count == 6'd15 && lvl != 1'b0) return 1'b0;
      if (p.bit_count >= 6'd16) p.frame_data = {p.frame_data[14:0], lvl};
      if (p.bit_count == 6'd31 && dev == PhyAddress &&
          !reg_write(p, p.frame_header[4:0], p.frame_data, rd_dly, nd)) return 1'b0;
    end
    p.bit_count = p.bit_count + 6'd1;
    if (p.bit_count == 6'd32) begin
      p.in_frame  = 1'b0;
      p.need_idle = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic logic mdc_fall(inout phy_state_t p);
    logic [4:0] dev;
    logic [15:0] rdv;
    logic [3:0] sh;
    p.mdio_out = 1'b1;
    if (!p.in_frame || p.bit_count < 6'd14 || p.frame_header[11:10] != 2'd2) return 1'b1;
    dev = p.frame_header[9:5];
    if (p.bit_count == 6'd15) begin
      p.mdio_out = (dev != PhyAddress);
      p.frame_data = 16'hffff;
      if (dev == PhyAddress) begin
        if (!reg_read(p, p.frame_header[4:0], rdv)) return 1'b0;
        p.frame_data = rdv;
      end
    end else if (p.bit_count >= 6'd16 && p.bit_count <= 6'd31) begin
      sh = 4'(6'd31 - p.bit_count);
      p.mdio_out = p.frame_data[sh];
    end
    return 1'b1;
  endfunction

  always_comb begin
    phy_state_t q;
    phy_state_t s;
    logic ok;
    logic [15:0] rd;
    logic valid, lvl_hi, lit, line;
    logic [3:0] sel;
    q = st_i;
    ok = 1'b0;
    rd = '0;
    case (in_i.operation)
      OP_ADVANCE: ok = time_step(q, in_i.now, neg_delay_i);
      OP_SET_PEER: begin
        if ((in_i.peer_ability & ~AbilityMask) == 16'd0 && in_i.peer_ability[4:0] == 5'd1
            && time_step(q, in_i.now, neg_delay_i)) begin
          ok = 1'b1;
          if (q.peer_here != in_i.peer_present ||
              q.peer_ability_word != in_i.peer_ability) begin
            q.peer_here = in_i.peer_present;
            q.peer_ability_word = in_i.peer_ability;
            if (q.reset_in_progress) link_drop(q);
            else ok = start_aneg(q, neg_delay_i);
          end
        end
      end
      OP_READ:  ok = reg_read(q, in_i.reg_index, rd);
      OP_WRITE: ok = reg_write(q, in_i.reg_index, in_i.write_value, reset_delay_i,
                               neg_delay_i);
      OP_PIN: begin
        if (!in_i.pin_value[3]) begin
          ok = 1'b1;
          if (!st_i.pin_latch[0] && in_i.pin_value[0])
            ok = mdc_rise(q, in_i.pin_value[1],
                          in_i.pin_value[1] ? in_i.pin_value[2] : 1'b1,
                          reset_delay_i, neg_delay_i);
          if (ok && st_i.pin_latch[0] && !in_i.pin_value[0]) ok = mdc_fall(q);
          q.pin_latch = in_i.pin_value[2:0];
        end
      end
      default: ok = 1'b0;
    endcase
    s = ok ? q : st_i;
    if (!ok || in_i.operation != OP_READ) rd = '0;

    valid = 1'b1;
    lvl_hi = 1'b1;
    lit = 1'b0;
    sel = s.led_mode[3:0];
    if (s.led_ctrl[3]) begin
      if (sel[3:2] != 2'd0) valid = 1'b0;
      else begin
        lit = s.link_state && ((sel & (s.control_reg[13] ? 4'd2 : 4'd1)) != 4'd0);
        lvl_hi = !lit;
      end
    end else if (s.led_ctrl[5:4] != 2'b11) begin
      valid = 1'b0;
    end else begin
      lit = s.link_state && !s.control_reg[13];
      lvl_hi = !lit;
    end
    line = s.pin_latch[1] ? s.pin_latch[2] : s.mdio_out;

    st_o = s;
    out_o.ok               = ok;
    out_o.read_data        = rd;
    out_o.link_up          = s.link_state;
    out_o.led0_valid       = valid;
    out_o.led0_high        = lvl_hi;
    out_o.pin_readback     = {line, s.pin_latch};
    out_o.deadline_pending = s.deadline_armed;
    out_o.deadline_time    = s.deadline_armed ? s.deadline_at : 64'd0;
  end

endmodule

@@ hdl/ethernet_phy_mdio_register_model.sv @@
// top level of the ethernet phy management register model
// depends on ephy_pkg and ephy_core
//
// one word in, one result word out, one word per cycle sustained: each accepted
// word is evaluated combinationally by ephy_core against the state register and
// the result lands in an output register. a new word is taken whenever the output
// register is empty or is being drained in the same cycle, so a stalled result
// holds the input side only while it waits. the user must write the two delay
// registers via the always-ready cfg port while idle; not enforced by the block.
module ethernet_phy_mdio_register_model import ephy_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  phy_state_t  state_q, state_d;
  out_word_t   res_q, res_d;
  logic        res_valid_q;
  logic [31:0] reset_delay_q, neg_delay_q;
  logic        take;

  // stall only while a result is held and not drained
  assign in_stall_o  = res_valid_q && out_stall_i;
  assign take        = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  ephy_core u_core (
    .st_i          (state_q),
    .in_i          (in_data_i),
    .reset_delay_i (reset_delay_q),
    .neg_delay_i   (neg_delay_q),
    .st_o          (state_d),
    .out_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= reset_state();
      res_valid_q   <= 1'b0;
      reset_delay_q <= 32'd1000000;
      neg_delay_q   <= 32'd100000000;
    end else begin
      if (take) state_q <= state_d;
      if (take) res_valid_q <= 1'b1;
      else if (!out_stall_i) res_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgResetDelay: reset_delay_q <= cfg_data_i;
          CfgNegDelay:   neg_delay_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule
